@@ design/srw_pkg.sv @@
// ----------------------------------------------------------------------------
// srw_pkg: shared types and constants of the serial packet rewriter
// Holds the configuration record, the register map, the micro-operation
// encoding and the microcode program that steps the datapath.
// ----------------------------------------------------------------------------
package srw_pkg;

  // Configuration register indices, in register-map order.
  typedef enum logic [2:0] {
    CFG_START_FIRST  = 3'd0,
    CFG_START_SECOND = 3'd1,
    CFG_FILL_BYTE3   = 3'd2,
    CFG_FILL_BYTE4   = 3'd3,
    CFG_FILL_BYTE8   = 3'd4,
    CFG_FILL_BYTE9   = 3'd5,
    CFG_TIMEOUT      = 3'd6
  } cfg_idx_e;

  localparam logic [7:0] START_FIRST_RST  = 8'h87;
  localparam logic [7:0] START_SECOND_RST = 8'hAA;
  localparam logic [7:0] FILL_BYTE3_RST   = 8'h15;
  localparam logic [7:0] FILL_BYTE4_RST   = 8'h6F;
  localparam logic [7:0] FILL_BYTE8_RST   = 8'h39;
  localparam logic [7:0] FILL_BYTE9_RST   = 8'h39;
  localparam logic [7:0] TIMEOUT_RST      = 8'd10;

  // Packet positions that are overwritten on a packet led by the first start byte.
  localparam int unsigned FILL_POS_A = 3;
  localparam int unsigned FILL_POS_B = 4;
  localparam int unsigned FILL_POS_C = 8;
  localparam int unsigned FILL_POS_D = 9;

  localparam logic [7:0] IDLE_SAT = 8'hFF;

  typedef struct packed {
    logic [7:0] start_first;
    logic [7:0] start_second;
    logic [7:0] fill_byte3;
    logic [7:0] fill_byte4;
    logic [7:0] fill_byte8;
    logic [7:0] fill_byte9;
    logic [7:0] timeout_ticks;
  } cfg_t;

  // Micro-operations carried out by the datapath.
  typedef enum logic [2:0] {
    UOP_NONE,
    UOP_DISPATCH,
    UOP_SUM_INIT,
    UOP_SUM_RD,
    UOP_SUM_ADD,
    UOP_OUT_INIT,
    UOP_OUT_RD,
    UOP_OUT_LD
  } uop_e;

  // Jump conditions tested by the sequencer.
  typedef enum logic [2:0] {
    JC_ALWAYS,
    JC_PKT_DONE,
    JC_SUM_END,
    JC_OUT_END,
    JC_SLOT_FREE
  } jcond_e;

  typedef logic [2:0] upc_t;

  typedef struct packed {
    logic   in_rdy;
    uop_e   op;
    jcond_e cond;
    upc_t   tgt_t;
    upc_t   tgt_f;
  } uword_t;

  // Control passed from the sequencer to the datapath.
  typedef struct packed {
    logic in_rdy;
    uop_e op;
  } ctrl_t;

  // Conditions reported by the datapath.
  typedef struct packed {
    logic pkt_done;
    logic sum_end;
    logic out_end;
    logic slot_free;
  } stat_t;

  localparam upc_t PC_WAIT     = 3'd0;
  localparam upc_t PC_SUM_INIT = 3'd1;
  localparam upc_t PC_SUM_RD   = 3'd2;
  localparam upc_t PC_SUM_ADD  = 3'd3;
  localparam upc_t PC_OUT_INIT = 3'd4;
  localparam upc_t PC_OUT_RD   = 3'd5;
  localparam upc_t PC_OUT_WAIT = 3'd6;
  localparam upc_t PC_OUT_LD   = 3'd7;

  // The microcode program.
  function automatic uword_t urom(upc_t pc);
    uword_t w;
    case (pc)
      PC_WAIT:     w = '{1'b1, UOP_DISPATCH, JC_PKT_DONE,  PC_SUM_INIT, PC_WAIT};
      PC_SUM_INIT: w = '{1'b0, UOP_SUM_INIT, JC_ALWAYS,    PC_SUM_RD,   PC_SUM_RD};
      PC_SUM_RD:   w = '{1'b0, UOP_SUM_RD,   JC_ALWAYS,    PC_SUM_ADD,  PC_SUM_ADD};
      PC_SUM_ADD:  w = '{1'b0, UOP_SUM_ADD,  JC_SUM_END,   PC_OUT_INIT, PC_SUM_RD};
      PC_OUT_INIT: w = '{1'b0, UOP_OUT_INIT, JC_ALWAYS,    PC_OUT_RD,   PC_OUT_RD};
      PC_OUT_RD:   w = '{1'b0, UOP_OUT_RD,   JC_ALWAYS,    PC_OUT_WAIT, PC_OUT_WAIT};
      PC_OUT_WAIT: w = '{1'b0, UOP_NONE,     JC_SLOT_FREE, PC_OUT_LD,   PC_OUT_WAIT};
      PC_OUT_LD:   w = '{1'b0, UOP_OUT_LD,   JC_OUT_END,   PC_WAIT,     PC_OUT_RD};
      default:     w = '{1'b0, UOP_NONE,     JC_ALWAYS,    PC_WAIT,     PC_WAIT};
    endcase
    return w;
  endfunction

endpackage

@@ design/srw_in_if.sv @@
// ----------------------------------------------------------------------------
// srw_in_if: input channel of the serial packet rewriter
// Carries received bytes and millisecond ticks with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface srw_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] in_byte;

  modport source (output valid, output command, output in_byte, input ready);
  modport sink   (input valid, input command, input in_byte, output ready);
endinterface

@@ design/srw_out_if.sv @@
// ----------------------------------------------------------------------------
// srw_out_if: output channel of the serial packet rewriter
// Carries forwarded packet bytes with a last-byte marker.
// ----------------------------------------------------------------------------
interface srw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

@@ design/srw_ram.sv @@
// ----------------------------------------------------------------------------
// srw_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module srw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 12
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/srw_useq.sv @@
// ----------------------------------------------------------------------------
// srw_useq: microcode sequencer
// Steps through the program held in the package and issues one control
// word per cycle, jumping on the conditions reported by the datapath.
// ----------------------------------------------------------------------------
module srw_useq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  srw_pkg::stat_t  stat_i,
  output srw_pkg::ctrl_t  ctrl_o
);

  srw_pkg::upc_t   pc_q, pc_d;
  srw_pkg::uword_t word;
  logic            take;

  assign word = srw_pkg::urom(pc_q);

  always_comb begin
    case (word.cond)
      srw_pkg::JC_ALWAYS:    take = 1'b1;
      srw_pkg::JC_PKT_DONE:  take = stat_i.pkt_done;
      srw_pkg::JC_SUM_END:   take = stat_i.sum_end;
      srw_pkg::JC_OUT_END:   take = stat_i.out_end;
      srw_pkg::JC_SLOT_FREE: take = stat_i.slot_free;
      default:               take = 1'b1;
    endcase
    pc_d = take ? word.tgt_t : word.tgt_f;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= srw_pkg::PC_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o.in_rdy = word.in_rdy;
  assign ctrl_o.op     = word.op;

endmodule

@@ design/srw_dp.sv @@
// ----------------------------------------------------------------------------
// srw_dp: datapath of the serial packet rewriter
// Packet store, hunt and collection state, idle timer, checksum
// accumulator and the output register, all driven by micro-operations.
// ----------------------------------------------------------------------------
module srw_dp #(
  parameter int unsigned PACKET_LENGTH = 12
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  srw_pkg::ctrl_t ctrl_i,
  input  srw_pkg::cfg_t  cfg_i,
  input  logic           in_valid_i,
  input  logic           command_i,
  input  logic [7:0]     in_byte_i,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output logic [7:0]     out_byte_o,
  output logic           out_last_o,
  output srw_pkg::stat_t stat_o
);

  localparam int unsigned AW = $clog2(PACKET_LENGTH);
  localparam int unsigned CW = $clog2(PACKET_LENGTH + 1);
  localparam logic [AW-1:0] IDX_LAST = AW'(PACKET_LENGTH - 1);
  localparam logic [AW-1:0] IDX_SUM_END = AW'(PACKET_LENGTH - 2);
  localparam logic [CW-1:0] CNT_FINAL = CW'(PACKET_LENGTH - 1);

  logic          hunting_q, hunting_d;
  logic          expect_q, expect_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [7:0]    idle_q, idle_d;
  logic [7:0]    sum_q, sum_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [7:0]    first_q, first_d;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_byte_q, out_byte_d;
  logic          out_last_q, out_last_d;

  logic          dispatch;
  logic [7:0]    want;
  logic [7:0]    idle_inc;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_re;
  logic [7:0]    ram_rdata;
  logic [7:0]    rw_val;
  logic          rewrite;
  logic [7:0]    neg_sum;

  assign dispatch = (ctrl_i.op == srw_pkg::UOP_DISPATCH) && ctrl_i.in_rdy && in_valid_i;
  assign want     = expect_q ? cfg_i.start_second : cfg_i.start_first;
  assign idle_inc = (idle_q == srw_pkg::IDLE_SAT) ? idle_q : idle_q + 8'd1;
  assign rewrite  = (first_q == cfg_i.start_first);
  assign neg_sum  = 8'd0 - sum_q;

  // Stored byte with the fill registers substituted where they apply.
  always_comb begin
    rw_val = ram_rdata;
    if (rewrite) begin
      if (idx_q == AW'(srw_pkg::FILL_POS_A)) begin
        rw_val = cfg_i.fill_byte3;
      end else if (idx_q == AW'(srw_pkg::FILL_POS_B)) begin
        rw_val = cfg_i.fill_byte4;
      end else if (idx_q == AW'(srw_pkg::FILL_POS_C)) begin
        rw_val = cfg_i.fill_byte8;
      end else if (idx_q == AW'(srw_pkg::FILL_POS_D)) begin
        rw_val = cfg_i.fill_byte9;
      end
    end
  end

  assign ram_waddr = hunting_q ? '0 : cnt_q[AW-1:0];
  assign ram_we    = dispatch && !command_i && (!hunting_q || (in_byte_i == want));
  assign ram_re    = (ctrl_i.op == srw_pkg::UOP_SUM_RD) || (ctrl_i.op == srw_pkg::UOP_OUT_RD);

  srw_ram #(
    .WIDTH (8),
    .DEPTH (PACKET_LENGTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_byte_i),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    hunting_d   = hunting_q;
    expect_d    = expect_q;
    cnt_d       = cnt_q;
    idle_d      = idle_q;
    sum_d       = sum_q;
    idx_d       = idx_q;
    first_d     = first_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;

    case (ctrl_i.op)
      srw_pkg::UOP_DISPATCH: begin
        if (dispatch) begin
          if (command_i) begin
            if (!hunting_q) begin
              if (idle_inc >= cfg_i.timeout_ticks) begin
                hunting_d = 1'b1;
                expect_d  = !expect_q;
                cnt_d     = '0;
                idle_d    = '0;
              end else begin
                idle_d = idle_inc;
              end
            end
          end else if (hunting_q) begin
            if (in_byte_i == want) begin
              first_d   = in_byte_i;
              cnt_d     = CW'(1);
              idle_d    = '0;
              hunting_d = 1'b0;
            end
          end else if (cnt_q == CNT_FINAL) begin
            hunting_d = 1'b1;
            expect_d  = !expect_q;
            cnt_d     = '0;
            idle_d    = '0;
          end else begin
            cnt_d  = cnt_q + CW'(1);
            idle_d = '0;
          end
        end
      end
      srw_pkg::UOP_SUM_INIT: begin
        idx_d = '0;
        sum_d = '0;
      end
      srw_pkg::UOP_SUM_ADD: begin
        sum_d = sum_q + rw_val;
        idx_d = idx_q + AW'(1);
      end
      srw_pkg::UOP_OUT_INIT: begin
        idx_d = '0;
      end
      srw_pkg::UOP_OUT_LD: begin
        out_valid_d = 1'b1;
        out_last_d  = (idx_q == IDX_LAST);
        out_byte_d  = (idx_q == IDX_LAST) ? {1'b0, neg_sum[6:0]} : rw_val;
        idx_d       = idx_q + AW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hunting_q   <= 1'b1;
      expect_q    <= 1'b0;
      cnt_q       <= '0;
      idle_q      <= '0;
      sum_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      hunting_q   <= hunting_d;
      expect_q    <= expect_d;
      cnt_q       <= cnt_d;
      idle_q      <= idle_d;
      sum_q       <= sum_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q    <= first_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign stat_o.pkt_done  = dispatch && !command_i && !hunting_q && (cnt_q == CNT_FINAL);
  assign stat_o.sum_end   = (idx_q == IDX_SUM_END);
  assign stat_o.out_end   = (idx_q == IDX_LAST);
  assign stat_o.slot_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule

@@ design/serial_packet_rewriter_core.sv @@
// ----------------------------------------------------------------------------
// serial_packet_rewriter_core: serial packet hunter, rewriter and forwarder
// Collects fixed-length packets from a byte stream, rewrites selected bytes
// and emits each packet with a fresh 7-bit checksum in its final byte.
// ----------------------------------------------------------------------------
// Usage. The input channel in_ch carries one item per transfer: command 0
// brings a received byte in in_byte, command 1 marks one millisecond tick.
// The output channel out_ch returns packet bytes in order, with out_last set
// on the final checksum byte. Both channels transfer when valid and ready are
// high at a rising clock edge.
// Timing. A byte or tick that does not complete a packet leaves the program
// in its waiting step, so such items may arrive back to back. The item that
// completes a packet starts the emit program: a checksum pass that reads and
// adds each of the first PACKET_LENGTH-1 stored bytes in turn, then a read,
// a wait for a free output slot and a load for each output byte. The single
// read port of the packet store and the microcode steps set this sequence.
// No input is taken while a packet is being emitted.
// Stalls. A stalled receiver holds the current result in the output
// register; the program waits before loading the next byte.
// Reset. rst_ni clears the sequencer, the hunt state and the idle timer and
// loads the configuration registers with their defaults; the block then hunts
// for the first start byte.
// ----------------------------------------------------------------------------
module serial_packet_rewriter_core #(
  parameter int unsigned PACKET_LENGTH = 12
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  srw_in_if.sink     in_ch,
  srw_out_if.source  out_ch,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i
);

  srw_pkg::cfg_t  cfg_q, cfg_d;
  srw_pkg::ctrl_t ctrl;
  srw_pkg::stat_t stat;

  // Configuration register file. Writes to an index beyond the map are
  // ignored, as the default arm leaves every register unchanged.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        srw_pkg::CFG_START_FIRST:  cfg_d.start_first   = cfg_data_i;
        srw_pkg::CFG_START_SECOND: cfg_d.start_second  = cfg_data_i;
        srw_pkg::CFG_FILL_BYTE3:   cfg_d.fill_byte3    = cfg_data_i;
        srw_pkg::CFG_FILL_BYTE4:   cfg_d.fill_byte4    = cfg_data_i;
        srw_pkg::CFG_FILL_BYTE8:   cfg_d.fill_byte8    = cfg_data_i;
        srw_pkg::CFG_FILL_BYTE9:   cfg_d.fill_byte9    = cfg_data_i;
        srw_pkg::CFG_TIMEOUT:      cfg_d.timeout_ticks = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_first   <= srw_pkg::START_FIRST_RST;
      cfg_q.start_second  <= srw_pkg::START_SECOND_RST;
      cfg_q.fill_byte3    <= srw_pkg::FILL_BYTE3_RST;
      cfg_q.fill_byte4    <= srw_pkg::FILL_BYTE4_RST;
      cfg_q.fill_byte8    <= srw_pkg::FILL_BYTE8_RST;
      cfg_q.fill_byte9    <= srw_pkg::FILL_BYTE9_RST;
      cfg_q.timeout_ticks <= srw_pkg::TIMEOUT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // The sequencer walks the microcode program; its waiting step is the only
  // one that raises ready on the input channel.
  srw_useq u_useq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  // The datapath holds the packet store, hunt state, timer, checksum and the
  // output register that decouples the receiver from the program.
  srw_dp #(
    .PACKET_LENGTH (PACKET_LENGTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_ch.valid),
    .command_i   (in_ch.command),
    .in_byte_i   (in_ch.in_byte),
    .out_ready_i (out_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_byte_o  (out_ch.out_byte),
    .out_last_o  (out_ch.out_last),
    .stat_o      (stat)
  );

  assign in_ch.ready = ctrl.in_rdy;

endmodule
